// File: rtl/gyro_tilt_direction_detector_top_defines.svh
// Assertion macros used by the tilt detector checker.
`ifndef GYRO_TILT_DIRECTION_DETECTOR_TOP_DEFINES_SVH
`define GYRO_TILT_DIRECTION_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GTDD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GTDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gtdd_pkg.sv
// Shared widths, register indexes and direction codes of the tilt direction detector.
package gtdd_pkg;

  localparam int unsigned RATE_W   = 16;
  localparam int unsigned MS_W     = 8;
  localparam int unsigned DECAY_W  = 16;
  localparam int unsigned LIMIT_W  = 22;
  localparam int unsigned MAP_W    = 4;
  localparam int unsigned TILT_W   = 23;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 48;
  localparam int unsigned M_TUSER_W  = 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [DIR_W-1:0] dir_t;

  localparam cfg_idx_t REG_BIAS_X    = 3'd0;
  localparam cfg_idx_t REG_BIAS_Y    = 3'd1;
  localparam cfg_idx_t REG_DECAY     = 3'd2;
  localparam cfg_idx_t REG_MAX_ANGLE = 3'd3;
  localparam cfg_idx_t REG_DEADZONE  = 3'd4;
  localparam cfg_idx_t REG_AXIS_MAP  = 3'd5;

  localparam dir_t DIR_UP    = 2'd0;
  localparam dir_t DIR_DOWN  = 2'd1;
  localparam dir_t DIR_LEFT  = 2'd2;
  localparam dir_t DIR_RIGHT = 2'd3;

  localparam logic [DECAY_W-1:0] DECAY_RESET    = 16'd65470;
  localparam logic [LIMIT_W-1:0] MAX_ANGLE_RESET = 22'd720000;
  localparam logic [LIMIT_W-1:0] DEADZONE_RESET  = 22'd240000;
  localparam logic [MAP_W-1:0]   AXIS_MAP_RESET  = 4'd1;

endpackage

// File: rtl/gyro_tilt_direction_detector_top.sv
// Tilt direction detector: integrates, decays and clamps two gyro angles, reports the direction and flags changes.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: rate_x, rate_y, elapsed_ms
//   m_*      out  m_tvalid/m_tready  tdata: direction, tilt_x, tilt_y; tuser: fired
//   cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (writes always taken)
//
// With elapsed_ms zero an item goes from idle to decide; otherwise it runs mul, add, abs per
// axis, decay per axis and millisecond, then clamp and decide. The single 25x16 multiplier
// serves both axes, one axis per cycle, for the integration products and every decay step.
// s_tready is high only while the sequencer is idle; a finished result waits in the output
// register, and a full output register stalls the sequencer in its last step.
// rst is synchronous: angles, direction memory, registers and handshakes return to reset values.
module gyro_tilt_direction_detector_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gtdd_pkg::S_TDATA_W-1:0]    s_tdata,  // rate_x, rate_y, elapsed_ms
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gtdd_pkg::M_TDATA_W-1:0]    m_tdata,  // direction, tilt_x, tilt_y
  output logic [gtdd_pkg::M_TUSER_W-1:0]    m_tuser,  // fired
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gtdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtdd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned MAG_W  = 25;
  localparam int unsigned SUM_W  = MAG_W + 1;
  localparam int unsigned PROD_W = MAG_W + gtdd_pkg::DECAY_W;
  localparam int unsigned RMAG_W = gtdd_pkg::RATE_W;
  localparam int unsigned RSUB_W = gtdd_pkg::RATE_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ABS,
    ST_DECAY,
    ST_CLAMP,
    ST_DECIDE
  } state_t;

  state_t state;
  logic   axis;
  logic [gtdd_pkg::MS_W-1:0] count;

  logic signed [gtdd_pkg::RATE_W-1:0] bias_x;
  logic signed [gtdd_pkg::RATE_W-1:0] bias_y;
  logic [gtdd_pkg::DECAY_W-1:0]       decay_per_ms;
  logic [gtdd_pkg::LIMIT_W-1:0]       max_angle;
  logic [gtdd_pkg::LIMIT_W-1:0]       deadzone;
  logic [gtdd_pkg::MAP_W-1:0]         axis_map;

  logic              ang_neg [2];
  logic [MAG_W-1:0]  ang_mag [2];
  logic              r_neg   [2];
  logic [RMAG_W-1:0] r_mag   [2];
  logic              p_neg;
  logic [MAG_W-1:0]  p_mag;
  logic signed [SUM_W-1:0] sum;
  logic              have_last;
  gtdd_pkg::dir_t    last_dir;

  logic signed [gtdd_pkg::RATE_W-1:0] in_rate_x;
  logic signed [gtdd_pkg::RATE_W-1:0] in_rate_y;
  logic [gtdd_pkg::MS_W-1:0]          in_ms;
  logic signed [RSUB_W-1:0] rx;
  logic signed [RSUB_W-1:0] ry;

  logic [MAG_W-1:0]            op_a;
  logic [gtdd_pkg::DECAY_W-1:0] op_b;
  logic [PROD_W-1:0]           prod;

  logic             ud_neg, lr_neg;
  logic [MAG_W-1:0] ud_mag, lr_mag, dom_mag;
  logic             ud_dom, ud_pos, lr_pos, active, fire;
  gtdd_pkg::dir_t   cand;
  logic signed [SUM_W-1:0] tc_x, tc_y;
  logic             out_free;

  function automatic logic signed [SUM_W-1:0] to_tc(input logic neg, input logic [MAG_W-1:0] mag);
    logic signed [SUM_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic [RMAG_W-1:0] abs_rate(input logic signed [RSUB_W-1:0] v);
    logic signed [RSUB_W-1:0] a;
    a = v[RSUB_W-1] ? -v : v;
    return a[RMAG_W-1:0];
  endfunction

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign in_rate_x = s_tdata[15:0];
  assign in_rate_y = s_tdata[31:16];
  assign in_ms     = s_tdata[39:32];
  assign rx = RSUB_W'(in_rate_x) - RSUB_W'(bias_x);
  assign ry = RSUB_W'(in_rate_y) - RSUB_W'(bias_y);

  // Shared multiplier: integration product or decay step of the selected axis.
  always_comb begin
    if (state == ST_MUL) begin
      op_a = MAG_W'(r_mag[axis]);
      op_b = gtdd_pkg::DECAY_W'(count);
    end else begin
      op_a = ang_mag[axis];
      op_b = decay_per_ms;
    end
    prod = PROD_W'(op_a) * PROD_W'(op_b);
  end

  always_comb begin
    ud_neg = (axis_map[0] ? ang_neg[1] : ang_neg[0]) ^ axis_map[1];
    ud_mag = axis_map[0] ? ang_mag[1] : ang_mag[0];
    lr_neg = (axis_map[2] ? ang_neg[1] : ang_neg[0]) ^ axis_map[3];
    lr_mag = axis_map[2] ? ang_mag[1] : ang_mag[0];
    ud_dom = (ud_mag >= lr_mag);
    dom_mag = ud_dom ? ud_mag : lr_mag;
    ud_pos = !ud_neg && (ud_mag != '0);
    lr_pos = !lr_neg && (lr_mag != '0);
    if (ud_dom) begin
      cand = ud_pos ? gtdd_pkg::DIR_DOWN : gtdd_pkg::DIR_UP;
    end else begin
      cand = lr_pos ? gtdd_pkg::DIR_RIGHT : gtdd_pkg::DIR_LEFT;
    end
    active = (dom_mag >= MAG_W'(deadzone));
    fire = active && (!have_last || (last_dir != cand));
    tc_x = to_tc(ang_neg[0], ang_mag[0]);
    tc_y = to_tc(ang_neg[1], ang_mag[1]);
    out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      axis         <= 1'b0;
      count        <= '0;
      bias_x       <= '0;
      bias_y       <= '0;
      decay_per_ms <= gtdd_pkg::DECAY_RESET;
      max_angle    <= gtdd_pkg::MAX_ANGLE_RESET;
      deadzone     <= gtdd_pkg::DEADZONE_RESET;
      axis_map     <= gtdd_pkg::AXIS_MAP_RESET;
      ang_neg[0]   <= 1'b0;
      ang_neg[1]   <= 1'b0;
      ang_mag[0]   <= '0;
      ang_mag[1]   <= '0;
      have_last    <= 1'b0;
      last_dir     <= gtdd_pkg::DIR_UP;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gtdd_pkg::REG_BIAS_X:    bias_x       <= cfg_data[15:0];
          gtdd_pkg::REG_BIAS_Y:    bias_y       <= cfg_data[15:0];
          gtdd_pkg::REG_DECAY:     decay_per_ms <= cfg_data[15:0];
          gtdd_pkg::REG_MAX_ANGLE: max_angle    <= cfg_data;
          gtdd_pkg::REG_DEADZONE:  deadzone     <= cfg_data;
          gtdd_pkg::REG_AXIS_MAP:  axis_map     <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && (state != ST_DECIDE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            r_neg[0] <= rx[RSUB_W-1];
            r_neg[1] <= ry[RSUB_W-1];
            r_mag[0] <= abs_rate(rx);
            r_mag[1] <= abs_rate(ry);
            count    <= in_ms;
            axis     <= 1'b0;
            state    <= (in_ms == '0) ? ST_DECIDE : ST_MUL;
          end
        end
        ST_MUL: begin
          p_mag <= prod[MAG_W-1:0];
          p_neg <= r_neg[axis];
          state <= ST_ADD;
        end
        ST_ADD: begin
          sum   <= to_tc(ang_neg[axis], ang_mag[axis]) + to_tc(p_neg, p_mag);
          state <= ST_ABS;
        end
        ST_ABS: begin
          ang_neg[axis] <= sum[SUM_W-1];
          ang_mag[axis] <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
          axis  <= ~axis;
          state <= axis ? ST_DECAY : ST_MUL;
        end
        ST_DECAY: begin
          ang_mag[axis] <= prod[PROD_W-1:gtdd_pkg::DECAY_W];
          axis <= ~axis;
          if (axis) begin
            count <= count - 1'b1;
            if (count == gtdd_pkg::MS_W'(1)) begin
              state <= ST_CLAMP;
            end
          end
        end
        ST_CLAMP: begin
          if (ang_mag[0] > MAG_W'(max_angle)) begin
            ang_mag[0] <= MAG_W'(max_angle);
          end
          if (ang_mag[1] > MAG_W'(max_angle)) begin
            ang_mag[1] <= MAG_W'(max_angle);
          end
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            if (active) begin
              if (fire) begin
                have_last <= 1'b1;
                last_dir  <= cand;
              end
            end else begin
              have_last <= 1'b0;
            end
            m_tvalid <= 1'b1;
            m_tuser  <= fire;
            m_tdata  <= {tc_y[gtdd_pkg::TILT_W-1:0], tc_x[gtdd_pkg::TILT_W-1:0], cand};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/gtdd_checker.sv
// Port-level checker for the tilt direction detector and its bind to the top level.
`include "gyro_tilt_direction_detector_top_defines.svh"

module gtdd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [gtdd_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [gtdd_pkg::M_TUSER_W-1:0]  m_tuser
);

  `GTDD_ASSERT_NOW(a_idle_after_reset, clk, rst, $past(rst), !m_tvalid, "result shown right after reset")
  `GTDD_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `GTDD_ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind gyro_tilt_direction_detector_top gtdd_checker u_gtdd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
